@@ design/fir25_pkg.sv @@
// ----------------------------------------------------------------------------
// fir25_pkg: shared types and constants of the 25-tap FIR filter
// Holds field widths, stream packing positions, control structs and the
// round/saturate function for the Q1.15 output.
// ----------------------------------------------------------------------------
package fir25_pkg;

    localparam int TAPS_DEFAULT = 25;

    localparam int SAMPLE_W = 16;
    localparam int TAP_IDX_W = 5;
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W = 40;
    localparam int FRAC_BITS = 15;
    localparam int QUOT_W = ACC_W + 1 - FRAC_BITS;

    // s_tdata packing, lowest bit first
    localparam int SAMPLE_LSB = 0;
    localparam int TAP_IDX_LSB = SAMPLE_LSB + SAMPLE_W;
    localparam int TAP_WEIGHT_LSB = TAP_IDX_LSB + TAP_IDX_W;
    localparam int S_FIELDS_W = TAP_WEIGHT_LSB + SAMPLE_W;
    localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = SAMPLE_W;

    // kind codes carried on s_tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF = 1'b1;

    typedef struct packed {
        logic shift;   // push a new sample at the head
        logic rotate;  // advance the line by one tap for the MAC sweep
    } dl_ctrl_t;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic mul_en;  // load the product register
        logic acc_en;  // add the product into the accumulator
    } mac_ctrl_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                clip;
    } rnd_result_t;

    // Round half up, floor shift by FRAC_BITS, saturate to SAMPLE_W bits.
    function automatic rnd_result_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    sum;
        logic signed [QUOT_W-1:0] quot;
        logic signed [QUOT_W-1:0] max_v;
        logic signed [QUOT_W-1:0] min_v;
        rnd_result_t              res;
        sum = (ACC_W+1)'(acc) + (ACC_W+1)'(signed'(1 << (FRAC_BITS - 1)));
        quot = $signed(sum[ACC_W:FRAC_BITS]);
        max_v = QUOT_W'((1 << (SAMPLE_W - 1)) - 1);
        min_v = -QUOT_W'(1 << (SAMPLE_W - 1));
        if (quot > max_v) begin
            res.value = {1'b0, {(SAMPLE_W-1){1'b1}}};
            res.clip = 1'b1;
        end else if (quot < min_v) begin
            res.value = {1'b1, {(SAMPLE_W-1){1'b0}}};
            res.clip = 1'b1;
        end else begin
            res.value = quot[SAMPLE_W-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

endpackage

@@ design/fir_filter_25_tap.sv @@
// ----------------------------------------------------------------------------
// fir_filter_25_tap: direct-form FIR filter, Q1.15, shared MAC
// Coefficient words load the tap weights; each sample word yields one
// rounded and saturated filter output.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Ports                       Contents
// s_       in   s_tvalid s_tready s_tdata   tdata: sample_in, tap_index,
//                        s_tuser            tap_weight; tuser: kind
// m_       out  m_tvalid m_tready m_tdata   tdata: filtered_out;
//                        m_tuser            tuser: clipped
//
// Sequence: a coefficient word is written on acceptance. A sample word runs
//   a sweep of TAPS passes through the single multiply-accumulate unit, then
//   empties its pipeline (coefficient read register, product register) and
//   loads the output; s_tready stays low until the sweep ends, so no new word
//   is taken while a sample is still being filtered.
// Reset: aresetn, synchronous, active low; clears the sequencer, the delay
//   line and the coefficient valid bits, so all taps read as zero.
// Stalls: a result word waits in the output register; the next word is still
//   accepted. The sweep holds before loading the output until it is free.
// ----------------------------------------------------------------------------
module fir_filter_25_tap #(
    parameter int TAPS = fir25_pkg::TAPS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] sample_in, [20:16] tap_index, [36:21] tap_weight, [39:37] zero
    input  logic [fir25_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] filtered_out
    output logic [fir25_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] clipped
    output logic                            m_tuser
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int IDX_CMP_W = 10;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          v1_reg;   // coefficient and sample registers hold a pair
    logic          v2_reg;   // product register holds a product

    logic                             s_accept;
    logic                             sample_accept;
    logic                             coef_accept;
    logic                             coef_in_range;
    logic [fir25_pkg::SAMPLE_W-1:0]   sample_in;
    logic [fir25_pkg::TAP_IDX_W-1:0]  tap_index;
    logic [fir25_pkg::SAMPLE_W-1:0]   tap_weight;
    logic                             last_tap;
    logic                             out_free;
    logic                             out_load;

    logic [fir25_pkg::SAMPLE_W-1:0]   weight_q;
    logic [fir25_pkg::SAMPLE_W-1:0]   sample_q;
    fir25_pkg::dl_ctrl_t              dl_ctrl;
    fir25_pkg::mac_ctrl_t             mac_ctrl;
    fir25_pkg::rnd_result_t           mac_result;

    logic                             m_tvalid_reg;
    logic [fir25_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                             m_tuser_reg;

    // unpack the input word
    assign sample_in = s_tdata[fir25_pkg::SAMPLE_LSB +: fir25_pkg::SAMPLE_W];
    assign tap_index = s_tdata[fir25_pkg::TAP_IDX_LSB +: fir25_pkg::TAP_IDX_W];
    assign tap_weight = s_tdata[fir25_pkg::TAP_WEIGHT_LSB +: fir25_pkg::SAMPLE_W];

    // take words only between sweeps
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign sample_accept = s_accept && (s_tuser == fir25_pkg::KIND_SAMPLE);
    assign coef_accept = s_accept && (s_tuser == fir25_pkg::KIND_COEF);

    // drop coefficient writes beyond the last tap
    assign coef_in_range = IDX_CMP_W'(tap_index) < IDX_CMP_W'(TAPS);

    assign last_tap = (cnt_reg == AW'(TAPS - 1));
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_FIN) && out_free;

    // ------------------------------------------------------------------
    // Sequencer: RUN issues one tap per cycle, DRAIN empties the MAC
    // pipeline, FIN waits for a free output register.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (sample_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                // last product enters the accumulator at this edge
                if (v2_reg && !v1_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            v1_reg <= (state_reg == ST_RUN);
            v2_reg <= v1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign dl_ctrl.shift = sample_accept;
    assign dl_ctrl.rotate = (state_reg == ST_RUN);

    assign mac_ctrl.clear = sample_accept;
    assign mac_ctrl.mul_en = v1_reg;
    assign mac_ctrl.acc_en = v2_reg;

    fir25_coef_mem #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_coef_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (coef_accept && coef_in_range),
        .wr_addr (AW'(tap_index)),
        .wr_data (tap_weight),
        .rd_addr (cnt_reg),
        .rd_data (weight_q)
    );

    fir25_delay_line #(
        .TAPS (TAPS)
    ) u_delay_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dl_ctrl),
        .sample  (sample_in),
        .head    (sample_q)
    );

    fir25_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .weight (weight_q),
        .sample (sample_q),
        .result (mac_result)
    );

    // ------------------------------------------------------------------
    // Output register: hold the word until the sink takes it
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= mac_result.value;
            m_tuser_reg <= mac_result.clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pipe_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!v1_reg && !v2_reg))
        else $error("MAC pipeline busy while idle");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= AW'(TAPS - 1)))
        else $error("tap counter out of range");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("result not presented after load");

    a_coef_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_accept |=> !$rose(m_tvalid))
        else $error("coefficient word produced a result");

endmodule

@@ design/fir25_coef_mem.sv @@
// ----------------------------------------------------------------------------
// fir25_coef_mem: coefficient store
// One write port, one registered read port; per-entry valid bits make
// never-written taps read as zero after reset.
// ----------------------------------------------------------------------------
module fir25_coef_mem #(
    parameter int TAPS = fir25_pkg::TAPS_DEFAULT,
    parameter int AW = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [fir25_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [fir25_pkg::SAMPLE_W-1:0] rd_data
);

    logic [fir25_pkg::SAMPLE_W-1:0] mem [TAPS];
    logic [TAPS-1:0]                valid_reg;
    logic [fir25_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/fir25_delay_line.sv @@
// ----------------------------------------------------------------------------
// fir25_delay_line: sample history
// Shift line of TAPS samples, newest at tap 0. During a sweep it rotates
// once per cycle so tap 0 presents x[n-k]; TAPS rotations bring it home.
// ----------------------------------------------------------------------------
module fir25_delay_line #(
    parameter int TAPS = fir25_pkg::TAPS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fir25_pkg::dl_ctrl_t           ctrl,
    input  logic [fir25_pkg::SAMPLE_W-1:0] sample,
    output logic [fir25_pkg::SAMPLE_W-1:0] head
);

    logic [fir25_pkg::SAMPLE_W-1:0] tap_reg [TAPS];
    logic [fir25_pkg::SAMPLE_W-1:0] tap_next [TAPS];
    logic [fir25_pkg::SAMPLE_W-1:0] head_reg;

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            tap_next[i] = tap_reg[i];
            if (ctrl.shift) begin
                tap_next[i] = (i == 0) ? sample : tap_reg[(i + TAPS - 1) % TAPS];
            end else if (ctrl.rotate) begin
                tap_next[i] = tap_reg[(i + 1) % TAPS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                tap_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < TAPS; i++) begin
                tap_reg[i] <= tap_next[i];
            end
        end
    end

    // register the head so it lines up with the coefficient read data
    always_ff @(posedge aclk) begin
        if (ctrl.rotate) begin
            head_reg <= tap_reg[0];
        end
    end

    assign head = head_reg;

endmodule

@@ design/fir25_mac.sv @@
// ----------------------------------------------------------------------------
// fir25_mac: shared multiply-accumulate unit
// One 16x16 signed multiplier with a product register, a 40-bit
// accumulator, and round/saturate of the final sum.
// ----------------------------------------------------------------------------
module fir25_mac (
    input  logic                          aclk,
    input  fir25_pkg::mac_ctrl_t          ctrl,
    input  logic [fir25_pkg::SAMPLE_W-1:0] weight,
    input  logic [fir25_pkg::SAMPLE_W-1:0] sample,
    output fir25_pkg::rnd_result_t        result
);

    logic signed [fir25_pkg::PROD_W-1:0] prod_reg;
    logic signed [fir25_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fir25_pkg::ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= $signed(weight) * $signed(sample);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.acc_en) begin
            acc_next = acc_reg + fir25_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign result = fir25_pkg::round_sat(acc_reg);

endmodule
